// File: design/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 64;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 6;
    localparam int LENGTH_W  = 7;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [BYTE_W-1:0] START_MARK = 8'h21;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'h0D;

    typedef enum logic [OP_W-1:0] {
        OP_RX_BYTE = 2'd0,
        OP_CONSUME = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] frame_length;
        logic                overflow_dropped;
        logic                read_hit;
    } stage_status_t;

endpackage

`default_nettype wire

// File: design/dfr_ram.sv
`default_nettype none

module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/delimited_frame_receiver.sv
`default_nettype none
// An accepted input is registered in the middle stage (status, store read),
// then in the output register. One item per cycle unless stalled; the store
// takes one write and one registered read per cycle; stalls lower s_tready.
// Reset: rst_n clears the receiver state and the valid flags asynchronously;
// the payload store is not cleared and holds undefined data until written.

module delimited_frame_receiver
    import dfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // op [1:0], rx_byte [9:2], read_index [15:10]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // frame_ready [0], frame_length [7:1], read_data [15:8],
    // overflow_dropped [16], zero fill [23:17]
    output logic      [M_DATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    op_t                 op;
    logic [BYTE_W-1:0]   rx_byte;
    logic [INDEX_W-1:0]  read_index;

    logic                in_frame_reg;
    logic                in_frame_next;
    logic [LENGTH_W-1:0] write_position_reg;
    logic [LENGTH_W-1:0] write_position_next;
    logic [LENGTH_W-1:0] pending_length_reg;
    logic [LENGTH_W-1:0] pending_length_next;

    logic                accept;
    logic                store_write;
    logic                dropped;
    logic                read_hit;

    logic                a_valid_reg;
    stage_status_t       a_status_reg;
    logic                a_advance;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [BYTE_W-1:0]   ram_rd_data;
    logic [BYTE_W-1:0]   read_data;

    assign op         = op_t'(s_tdata[1:0]);
    assign rx_byte    = s_tdata[9:2];
    assign read_index = s_tdata[15:10];

    assign a_advance = a_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_advance;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        in_frame_next       = in_frame_reg;
        write_position_next = write_position_reg;
        pending_length_next = pending_length_reg;
        store_write         = 1'b0;
        dropped             = 1'b0;
        read_hit            = 1'b0;
        unique case (op)
            OP_RX_BYTE:
            begin
                if (!in_frame_reg)
                begin
                    if (pending_length_reg == '0 && rx_byte == START_MARK)
                    begin
                        in_frame_next       = 1'b1;
                        write_position_next = '0;
                    end
                end
                else if (rx_byte == END_MARK)
                begin
                    in_frame_next       = 1'b0;
                    pending_length_next = write_position_reg;
                end
                else if (write_position_reg >= LENGTH_W'(BUFFER_DEPTH))
                begin
                    in_frame_next = 1'b0;
                    dropped       = 1'b1;
                end
                else
                begin
                    store_write         = 1'b1;
                    write_position_next = write_position_reg + 1'b1;
                end
            end
            OP_CONSUME:
            begin
                pending_length_next = '0;
            end
            OP_READ:
            begin
                read_hit = (LENGTH_W'(read_index) < LENGTH_W'(BUFFER_DEPTH));
            end
            default:
            begin
                read_hit = 1'b0;
            end
        endcase
    end

    dfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && store_write),
        .wr_addr (ADDR_W'(write_position_reg)),
        .wr_data (rx_byte),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(read_index)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            write_position_reg <= '0;
            pending_length_reg <= '0;
            a_valid_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_frame_reg       <= in_frame_next;
                write_position_reg <= write_position_next;
                pending_length_reg <= pending_length_next;
            end
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_status_reg.frame_length     <= pending_length_next;
            a_status_reg.overflow_dropped <= dropped;
            a_status_reg.read_hit         <= read_hit;
        end
        if (a_advance)
        begin
            out_data_reg <= {
                7'b0,
                a_status_reg.overflow_dropped,
                read_data,
                a_status_reg.frame_length,
                (a_status_reg.frame_length != '0)
            };
        end
    end

    assign read_data = a_status_reg.read_hit ? ram_rd_data : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        write_position_reg <= LENGTH_W'(BUFFER_DEPTH))
    else $error("Write position ran past the end of the payload store.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_length_reg != '0 |-> !in_frame_reg)
    else $error("A new frame started while an earlier frame was pending.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[7:1] != '0)))
    else $error("Frame ready flag disagrees with the frame length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_advance |=> a_valid_reg && $stable(a_status_reg))
    else $error("Held middle stage lost or changed its status.");
`endif

endmodule

`default_nettype wire
